// ===== hdl/aes_pkg.sv =====
// AES-128 shared package: byte tables, round helpers, pipeline constants.
// No dependencies; used by every module in hdl/.
package aes_pkg;

  localparam int NumRounds = 10;
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 1'b1;

  typedef logic [127:0] blk_t;

  typedef struct packed {
    logic valid;
    logic mode;
  } stage_ctl_t;

  localparam logic [7:0] SboxTab [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] InvSboxTab [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // byte k of a block lives at bits [127-8k -: 8]
  function automatic logic [7:0] get_byte(input blk_t b, input int k);
    return b[127-8*k -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SboxTab[w[31:24]], SboxTab[w[23:16]], SboxTab[w[15:8]], SboxTab[w[7:0]]};
  endfunction

  function automatic blk_t mix_cols(input blk_t s);
    blk_t r;
    logic [7:0] a [4];
    logic [7:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) a[i] = get_byte(s, 4*c+i);
      t = a[0] ^ a[1] ^ a[2] ^ a[3];
      for (int i = 0; i < 4; i++)
        r[127-8*(4*c+i) -: 8] = a[i] ^ t ^ xtime(a[i] ^ a[(i+1)%4]);
    end
    return r;
  endfunction

  function automatic blk_t inv_mix_cols(input blk_t s);
    blk_t r;
    logic [7:0] a [4];
    logic [7:0] u, v;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) a[i] = get_byte(s, 4*c+i);
      u = xtime(xtime(a[0] ^ a[2]));
      v = xtime(xtime(a[1] ^ a[3]));
      for (int i = 0; i < 4; i++)
        r[127-8*(4*c+i) -: 8] = a[i] ^ (((i % 2) == 1) ? v : u);
    end
    return mix_cols(r);
  endfunction

  // forward: sub + shift; inverse: inv shift + inv sub
  function automatic blk_t sub_shift(input blk_t s, input logic inv);
    blk_t r;
    int src;
    for (int c = 0; c < 4; c++)
      for (int j = 0; j < 4; j++) begin
        src = inv ? ((c - j + 4) % 4) : ((c + j) % 4);
        r[127-8*(4*c+j) -: 8] = inv ? InvSboxTab[get_byte(s, 4*src+j)]
                                    : SboxTab[get_byte(s, 4*src+j)];
      end
    return r;
  endfunction

endpackage

// ===== hdl/aes_block_cipher.sv =====
// AES-128 top level: key registers, input stage, ten round stages, output.
// Depends on aes_pkg, aes_key_sched, aes_round.

// Fully unrolled AES-128 pipeline. One block is accepted per clock when the
// output side keeps up and the round keys have settled. Each block passes
// one whitening stage plus ten round stages, one register each. The whole
// pipe advances together: it moves whenever the output register is empty or
// being taken, so a stall freezes every stage and no beat is lost. Each beat
// carries its own mode bit, so encrypt and decrypt beats may be mixed freely.
// Round keys are recomputed from the key registers through a registered
// schedule; in_ready is held low after reset or a key write until the
// schedule has refilled, so no block is taken before the new round keys
// are in place.
module aes_block_cipher (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [aes_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [63:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic [63:0]                  block_high,
  input  logic [63:0]                  block_low,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [63:0]                  result_high,
  output logic [63:0]                  result_low
);

  localparam int NR = aes_pkg::NumRounds;
  localparam int SettleW = $clog2(NR + 2);
  localparam logic [SettleW-1:0] SettleCycles = SettleW'(NR + 1);

  logic [63:0] key_high, key_low;
  aes_pkg::blk_t rkey [NR+1];
  aes_pkg::stage_ctl_t ctl [NR+1];
  aes_pkg::blk_t st [NR+1];
  aes_pkg::blk_t st0_next;
  logic adv;
  logic [SettleW-1:0] settle;
  logic keys_ok;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        aes_pkg::RegKeyHigh: key_high <= cfg_data;
        aes_pkg::RegKeyLow:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // schedule refill: one round key per cycle, eleven in all
  always_ff @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready)) begin
      settle <= SettleCycles;
    end else if (!keys_ok) begin
      settle <= settle - 1'b1;
    end
  end

  assign keys_ok = (settle == '0);

  aes_key_sched u_ks (.clk(clk), .key({key_high, key_low}), .rkey(rkey));

  // last stage is the output register; advance when it is free or drained
  assign adv      = !ctl[NR].valid || out_ready;
  assign in_ready = adv && keys_ok;

  // whitening: round key 0 for encrypt, round key 10 for decrypt
  assign st0_next = {block_high, block_low} ^ (mode ? rkey[NR] : rkey[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (adv) begin
      ctl[0] <= '{valid: in_valid && keys_ok, mode: mode};
    end
    if (adv) begin
      st[0] <= st0_next;
    end
  end

  for (genvar r = 1; r <= NR; r++) begin : g_round
    aes_round #(.LastRound(r == NR)) u_round (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .ctl_in   (ctl[r-1]),
      .state_in (st[r-1]),
      .key_enc  (rkey[r]),
      .key_dec  (rkey[NR-r]),
      .ctl      (ctl[r]),
      .state    (st[r])
    );
  end

  assign out_valid   = ctl[NR].valid;
  assign result_high = st[NR][127:64];
  assign result_low  = st[NR][63:0];

endmodule

// ===== hdl/aes_key_sched.sv =====
// AES-128 key schedule: all eleven round keys from the configured key. Depends on aes_pkg.
// Keys are registered per round; the user must change the key only while idle, which the block does not enforce.
module aes_key_sched (
  input  logic               clk,
  input  logic [127:0]       key,
  output aes_pkg::blk_t      rkey [aes_pkg::NumRounds+1]
);

  aes_pkg::blk_t rk_next [aes_pkg::NumRounds+1];
  logic [7:0]    rcon [aes_pkg::NumRounds+1];

  // one round key per stage, each from the registered previous one
  always_comb begin
    rk_next[0] = key;
    rcon[0] = 8'h00;
    rcon[1] = 8'h01;
    for (int r = 2; r <= aes_pkg::NumRounds; r++) rcon[r] = aes_pkg::xtime(rcon[r-1]);
    for (int r = 1; r <= aes_pkg::NumRounds; r++) begin
      logic [31:0] w0, w1, w2, w3, t;
      w0 = rkey[r-1][127:96];
      w1 = rkey[r-1][95:64];
      w2 = rkey[r-1][63:32];
      w3 = rkey[r-1][31:0];
      t  = aes_pkg::sub_word({w3[23:0], w3[31:24]}) ^ {rcon[r], 24'h0};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      rk_next[r] = {w0, w1, w2, w3};
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r <= aes_pkg::NumRounds; r++) rkey[r] <= rk_next[r];
  end

endmodule

// ===== hdl/aes_round.sv =====
// One AES round stage, forward or inverse, with a stall-aware register.
// Depends on aes_pkg.
module aes_round #(
  parameter bit LastRound = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  aes_pkg::stage_ctl_t ctl_in,
  input  aes_pkg::blk_t       state_in,
  input  aes_pkg::blk_t       key_enc,
  input  aes_pkg::blk_t       key_dec,
  output aes_pkg::stage_ctl_t ctl,
  output aes_pkg::blk_t       state
);

  aes_pkg::blk_t state_next;
  aes_pkg::blk_t ss;

  always_comb begin
    ss = aes_pkg::sub_shift(state_in, ctl_in.mode);
    if (!ctl_in.mode) begin
      state_next = (LastRound ? ss : aes_pkg::mix_cols(ss)) ^ key_enc;
    end else begin
      state_next = LastRound ? (ss ^ key_dec) : aes_pkg::inv_mix_cols(ss ^ key_dec);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl <= ctl_in;
    end
    if (adv) begin
      state <= state_next;
    end
  end

endmodule
